// ===== rtl/frt_pkg.sv =====
package frt_pkg;

  localparam int unsigned SlotsDef  = 8;
  localparam int unsigned PiecesDef = 16;

  typedef enum logic [1:0] {
    MODE_ADD      = 2'd0,
    MODE_RETRIEVE = 2'd1,
    MODE_REMOVE   = 2'd2,
    MODE_TICK     = 2'd3
  } mode_e;

  typedef enum logic [3:0] {
    ST_OK         = 4'd0,
    ST_INVALID    = 4'd1,
    ST_MEMORY     = 4'd2,
    ST_TOO_MANY   = 4'd3,
    ST_LEN_MISM   = 4'd4,
    ST_REORDER    = 4'd5,
    ST_LIST_FULL  = 4'd6,
    ST_NOT_FOUND  = 4'd7,
    ST_INCOMPLETE = 4'd8
  } status_e;

  localparam logic [2:0] REG_STRICT   = 3'd0;
  localparam logic [2:0] REG_MAX_MSG  = 3'd1;
  localparam logic [2:0] REG_MAX_PCS  = 3'd2;
  localparam logic [2:0] REG_MEM_LIM  = 3'd3;
  localparam logic [2:0] REG_MAX_OPEN = 3'd4;
  localparam logic [2:0] REG_TIMEOUT  = 3'd5;
  localparam logic [2:0] REG_DROP_DUP = 3'd6;
  localparam logic [2:0] REG_REORDER  = 3'd7;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] seq_id;
    logic [23:0] piece_offset;
    logic [23:0] piece_length;
    logic [23:0] message_length;
  } req_t;

  typedef struct packed {
    logic [3:0] status;
    logic       done_res;
    logic       was_duplicate;
    logic [3:0] expired_count;
  } rsp_t;

  typedef struct packed {
    logic        strict_checks;
    logic [23:0] max_message_bytes;
    logic [4:0]  max_pieces;
    logic [31:0] memory_limit;
    logic [3:0]  max_open;
    logic [31:0] timeout_ticks;
    logic        drop_duplicates;
    logic        allow_reorder;
  } cfg_t;

  // Divider handshake between the engine and the divider.
  typedef struct packed {
    logic        start;
    logic [24:0] dividend;
    logic [23:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [24:0] quotient;
  } div_rsp_t;

endpackage

// ===== rtl/frt_if.sv =====
interface frt_req_if;
  import frt_pkg::*;
  logic valid;
  logic ready;
  req_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface frt_rsp_if;
  import frt_pkg::*;
  logic valid;
  logic ready;
  rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/fragment_reassembly_tracker.sv =====
// Channel   Direction  Handshake     Payload
// req       in         valid/ready   mode, seq_id, piece_offset, piece_length, message_length
// rsp       out        valid/ready   status, done_res, was_duplicate, expired_count
// cfg       in         APB write     eight registers at byte address 4*i
//
// One item at a time. An add runs the serial divider for the piece-count estimate,
// then scans the slots for its sequence number and walks the stored pieces in the
// duplicate check, the sorted insert and the coverage check. A tick walks the
// SLOTS slots, one a cycle. Retrieve and remove scan the slots for the one to free.
// Reset idles the engine and clears only the slot valid bits and the counters.
// The result is held in a register until taken, and ready stays low meanwhile.
module fragment_reassembly_tracker #(
  parameter int unsigned SLOTS           = frt_pkg::SlotsDef,
  parameter int unsigned PIECES_PER_SLOT = frt_pkg::PiecesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  frt_req_if.sink     req,
  frt_rsp_if.source   rsp,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import frt_pkg::*;

  cfg_t     cfg;
  div_req_t div_req;
  div_rsp_t div_rsp;

  frt_cfg u_cfg (
    .clk_i, .rst_ni, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready,
    .cfg_o(cfg)
  );

  // The divider is the arithmetic unit for the estimate check.
  frt_div u_div (.clk_i, .rst_ni, .req_i(div_req), .rsp_o(div_rsp));

  frt_engine #(.SLOTS(SLOTS), .PIECES_PER_SLOT(PIECES_PER_SLOT)) u_engine (
    .clk_i, .rst_ni, .cfg_i(cfg),
    .in_valid_i(req.valid), .in_ready_o(req.ready), .in_data_i(req.data),
    .out_valid_o(rsp.valid), .out_ready_i(rsp.ready), .out_data_o(rsp.data),
    .div_req_o(div_req), .div_rsp_i(div_rsp)
  );
endmodule

// ===== rtl/frt_cfg.sv =====
module frt_cfg (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output frt_pkg::cfg_t     cfg_o
);
  import frt_pkg::*;

  cfg_t       cfg_q, cfg_d;
  logic [2:0] idx;

  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (psel && penable && pwrite) begin
      unique case (idx)
        REG_STRICT:   cfg_d.strict_checks     = pwdata[0];
        REG_MAX_MSG:  cfg_d.max_message_bytes = pwdata[23:0];
        REG_MAX_PCS:  cfg_d.max_pieces        = pwdata[4:0];
        REG_MEM_LIM:  cfg_d.memory_limit      = pwdata;
        REG_MAX_OPEN: cfg_d.max_open          = pwdata[3:0];
        REG_TIMEOUT:  cfg_d.timeout_ticks     = pwdata;
        REG_DROP_DUP: cfg_d.drop_duplicates   = pwdata[0];
        REG_REORDER:  cfg_d.allow_reorder     = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_STRICT:   prdata = {31'd0, cfg_q.strict_checks};
      REG_MAX_MSG:  prdata = {8'd0, cfg_q.max_message_bytes};
      REG_MAX_PCS:  prdata = {27'd0, cfg_q.max_pieces};
      REG_MEM_LIM:  prdata = cfg_q.memory_limit;
      REG_MAX_OPEN: prdata = {28'd0, cfg_q.max_open};
      REG_TIMEOUT:  prdata = cfg_q.timeout_ticks;
      REG_DROP_DUP: prdata = {31'd0, cfg_q.drop_duplicates};
      REG_REORDER:  prdata = {31'd0, cfg_q.allow_reorder};
      default:      prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{strict_checks: 1'b1, max_message_bytes: 24'hFFFFFF, max_pieces: 5'd16,
                 memory_limit: 32'd1048576, max_open: 4'd8, timeout_ticks: 32'd30000,
                 drop_duplicates: 1'b1, allow_reorder: 1'b1};
    end else begin
      cfg_q <= cfg_d;
    end
  end
endmodule

// ===== rtl/frt_div.sv =====
// Restoring divider, one quotient bit per cycle.
module frt_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frt_pkg::div_req_t req_i,
  output frt_pkg::div_rsp_t rsp_o
);
  import frt_pkg::*;

  logic        busy_q;
  logic        done_q;
  logic [4:0]  cnt_q;
  logic [24:0] quo_q;
  logic [24:0] rem_q;
  logic [23:0] dsr_q;
  logic [25:0] trial;
  logic [25:0] shifted;

  assign shifted = {rem_q, quo_q[24]};
  assign trial   = shifted - {2'd0, dsr_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      quo_q  <= '0;
      rem_q  <= '0;
      dsr_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (req_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= 5'd0;
        quo_q  <= req_i.dividend;
        rem_q  <= '0;
        dsr_q  <= req_i.divisor;
      end else if (busy_q) begin
        if (!trial[25]) begin
          rem_q <= trial[24:0];
          quo_q <= {quo_q[23:0], 1'b1};
        end else begin
          rem_q <= shifted[24:0];
          quo_q <= {quo_q[23:0], 1'b0};
        end
        cnt_q <= cnt_q + 5'd1;
        if (cnt_q == 5'd24) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  assign rsp_o.done     = done_q;
  assign rsp_o.quotient = quo_q;
endmodule

// ===== rtl/frt_engine.sv =====
module frt_engine #(
  parameter int unsigned SLOTS           = frt_pkg::SlotsDef,
  parameter int unsigned PIECES_PER_SLOT = frt_pkg::PiecesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  frt_pkg::cfg_t     cfg_i,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  frt_pkg::req_t     in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output frt_pkg::rsp_t     out_data_o,
  output frt_pkg::div_req_t div_req_o,
  input  frt_pkg::div_rsp_t div_rsp_i
);
  import frt_pkg::*;

  localparam int unsigned SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned PW    = (PIECES_PER_SLOT > 1) ? $clog2(PIECES_PER_SLOT) : 1;
  localparam int unsigned CW    = $clog2(PIECES_PER_SLOT + 1);
  localparam int unsigned OW    = $clog2(SLOTS + 1);
  localparam int unsigned DEPTH = SLOTS * PIECES_PER_SLOT;
  localparam int unsigned AW    = SW + PW;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_CHECK, S_SLOTSCAN, S_DUP_RD, S_DUP_CHK, S_INS_RD, S_INS_WR,
    S_COV_RD, S_COV_CHK, S_TICK, S_FREE, S_OUT
  } state_e;

  state_e state_q;

  logic [SLOTS-1:0] valid_q;
  logic [15:0]      seq_q   [SLOTS];
  logic [23:0]      total_q [SLOTS];
  logic [31:0]      recv_q  [SLOTS];
  logic [CW-1:0]    pcnt_q  [SLOTS];
  logic [SLOTS-1:0] comp_q;
  logic [31:0]      age_q   [SLOTS];
  logic [31:0]      held_q;
  logic [OW-1:0]    open_q;

  // Piece store, one entry holds offset and length.
  logic [47:0]      mem [DEPTH];
  logic [47:0]      rd_q;

  req_t             req_q;
  rsp_t             rsp_q;
  logic [SW-1:0]    slot_q;
  logic [SW:0]      scan_q;
  logic             found_q;
  logic             free_ok_q;
  logic [SW-1:0]    free_q;
  logic [CW-1:0]    idx_q;
  logic [23:0]      next_q;
  logic [3:0]       exp_q;

  logic [AW-1:0]    rd_addr;
  logic             rd_en;
  logic [AW-1:0]    wr_addr;
  logic             wr_en;
  logic [47:0]      wr_data;
  logic [SW-1:0]    scan_s;
  logic [24:0]      sum_oe;
  logic [32:0]      mem_need;
  logic [31:0]      recv_s;
  logic [31:0]      age_inc;
  logic [23:0]      rd_off;
  logic [23:0]      rd_len;
  logic [23:0]      rd_end;

  assign scan_s  = scan_q[SW-1:0];
  assign recv_s  = recv_q[slot_q];
  assign rd_off  = rd_q[47:24];
  assign rd_len  = rd_q[23:0];
  assign rd_end  = rd_off + rd_len;
  assign sum_oe  = {1'b0, req_q.piece_offset} + {1'b0, req_q.piece_length};
  assign mem_need = {1'b0, held_q} + {9'd0, req_q.piece_length};
  assign age_inc = (age_q[scan_s] == 32'hFFFFFFFF) ? age_q[scan_s] : age_q[scan_s] + 32'd1;

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);
  assign out_data_o  = rsp_q;

  assign div_req_o.start    = (state_q == S_IDLE) && in_valid_i &&
                              (in_data_i.mode == MODE_ADD);
  assign div_req_o.dividend = {1'b0, in_data_i.message_length} +
                              {1'b0, in_data_i.piece_length} - 25'd1;
  assign div_req_o.divisor  = in_data_i.piece_length;

  // Memory port control: read address from slot and index, or index minus one in the insert read.
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = {slot_q, idx_q[PW-1:0]};
    wr_en   = 1'b0;
    wr_addr = {slot_q, idx_q[PW-1:0]};
    wr_data = rd_q;
    unique case (state_q)
      S_DUP_RD, S_COV_RD: rd_en = 1'b1;
      S_INS_RD: begin
        rd_en   = 1'b1;
        rd_addr = {slot_q, PW'(idx_q - CW'(1))};
      end
      S_INS_WR: begin
        // The reorder test cycle only looks at the last piece and stores nothing.
        wr_en = !rsp_q.expired_count[0];
        if (idx_q == '0 || rd_off <= req_q.piece_offset) begin
          wr_data = {req_q.piece_offset, req_q.piece_length};
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    if (rd_en) rd_q <= mem[rd_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      valid_q <= '0;
      held_q  <= '0;
      open_q  <= '0;
    end else begin
      unique case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            req_q     <= in_data_i;
            rsp_q     <= '0;
            scan_q    <= '0;
            found_q   <= 1'b0;
            free_ok_q <= 1'b0;
            exp_q     <= '0;
            unique case (mode_e'(in_data_i.mode))
              MODE_ADD:  state_q <= S_DIV;
              MODE_TICK: state_q <= S_TICK;
              default:   state_q <= S_SLOTSCAN;
            endcase
          end
        end
        S_DIV: if (div_rsp_i.done) state_q <= S_CHECK;
        S_CHECK: begin
          if (req_q.piece_length == '0 || req_q.piece_offset >= req_q.message_length ||
              sum_oe > {1'b0, req_q.message_length} ||
              (cfg_i.strict_checks &&
               (req_q.message_length > cfg_i.max_message_bytes ||
                div_rsp_i.quotient > {20'd0, cfg_i.max_pieces}))) begin
            rsp_q.status <= ST_INVALID;
            state_q      <= S_OUT;
          end else if (mem_need > {1'b0, cfg_i.memory_limit}) begin
            rsp_q.status <= ST_MEMORY;
            state_q      <= S_OUT;
          end else begin
            state_q <= S_SLOTSCAN;
          end
        end
        S_SLOTSCAN: begin
          // One slot per cycle: match on seq, remember lowest free slot.
          if (scan_q < (SW+1)'(SLOTS) && !found_q) begin
            if (valid_q[scan_s] && seq_q[scan_s] == req_q.seq_id) begin
              found_q <= 1'b1;
              slot_q  <= scan_s;
            end else if (!valid_q[scan_s] && !free_ok_q) begin
              free_ok_q <= 1'b1;
              free_q    <= scan_s;
            end
            scan_q <= scan_q + (SW+1)'(1);
          end else if (req_q.mode == MODE_ADD) begin
            if (!found_q) begin
              if ({{(8-OW){1'b0}}, open_q} >= {4'd0, cfg_i.max_open} || !free_ok_q) begin
                rsp_q.status <= ST_TOO_MANY;
                state_q      <= S_OUT;
              end else begin
                slot_q               <= free_q;
                valid_q[free_q]      <= 1'b1;
                seq_q[free_q]        <= req_q.seq_id;
                total_q[free_q]      <= req_q.message_length;
                recv_q[free_q]       <= '0;
                pcnt_q[free_q]       <= '0;
                comp_q[free_q]       <= 1'b0;
                age_q[free_q]        <= '0;
                open_q               <= open_q + OW'(1);
                idx_q                <= '0;
                state_q              <= S_DUP_RD;
              end
            end else if (total_q[slot_q] != req_q.message_length) begin
              rsp_q.status <= ST_LEN_MISM;
              state_q      <= S_OUT;
            end else begin
              idx_q   <= '0;
              state_q <= S_DUP_RD;
            end
          end else if (!found_q) begin
            rsp_q.status <= ST_NOT_FOUND;
            state_q      <= S_OUT;
          end else if (req_q.mode == MODE_RETRIEVE && !comp_q[slot_q]) begin
            rsp_q.status <= ST_INCOMPLETE;
            state_q      <= S_OUT;
          end else begin
            rsp_q.done_res <= (req_q.mode == MODE_RETRIEVE);
            state_q        <= S_FREE;
          end
        end
        S_DUP_RD: begin
          // A fresh slot has no pieces, so its stale entries never count.
          if (total_q[slot_q] != req_q.message_length) begin
            rsp_q.status <= ST_LEN_MISM;
            state_q      <= S_OUT;
          end else if (cfg_i.drop_duplicates && idx_q < pcnt_q[slot_q]) begin
            state_q <= S_DUP_CHK;
          end else if (pcnt_q[slot_q] != '0 && !cfg_i.allow_reorder) begin
            idx_q   <= pcnt_q[slot_q];
            state_q <= S_INS_RD;
            rsp_q.expired_count <= 4'd1;
          end else if (pcnt_q[slot_q] >= CW'(PIECES_PER_SLOT)) begin
            rsp_q.status <= ST_LIST_FULL;
            state_q      <= S_OUT;
          end else begin
            idx_q   <= pcnt_q[slot_q];
            state_q <= S_INS_RD;
          end
        end
        S_DUP_CHK: begin
          if (rd_off == req_q.piece_offset && rd_len == req_q.piece_length) begin
            rsp_q.was_duplicate <= 1'b1;
            rsp_q.done_res      <= comp_q[slot_q];
            state_q             <= S_OUT;
          end else begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_DUP_RD;
          end
        end
        S_INS_RD: begin
          // expired_count is borrowed as a flag for the reorder test, set in S_DUP_RD and read in S_INS_WR.
          if (idx_q == '0) begin
            state_q <= S_INS_WR;
          end else begin
            state_q <= S_INS_WR;
          end
        end
        S_INS_WR: begin
          if (rsp_q.expired_count[0]) begin
            rsp_q.expired_count <= '0;
            if (req_q.piece_offset < rd_off) begin
              rsp_q.status <= ST_REORDER;
              state_q      <= S_OUT;
            end else if (pcnt_q[slot_q] >= CW'(PIECES_PER_SLOT)) begin
              rsp_q.status <= ST_LIST_FULL;
              state_q      <= S_OUT;
            end else begin
              state_q <= S_INS_RD;
            end
          end else if (idx_q == '0 || rd_off <= req_q.piece_offset) begin
            pcnt_q[slot_q] <= pcnt_q[slot_q] + CW'(1);
            recv_q[slot_q] <= recv_s + {8'd0, req_q.piece_length};
            held_q         <= held_q + {8'd0, req_q.piece_length};
            idx_q          <= '0;
            next_q         <= '0;
            state_q        <= S_COV_RD;
          end else begin
            idx_q   <= idx_q - CW'(1);
            state_q <= S_INS_RD;
          end
        end
        S_COV_RD: begin
          if (idx_q == pcnt_q[slot_q]) begin
            if (recv_s == {8'd0, total_q[slot_q]} && next_q == total_q[slot_q]) begin
              comp_q[slot_q] <= 1'b1;
              rsp_q.done_res <= 1'b1;
            end
            state_q <= S_OUT;
          end else begin
            state_q <= S_COV_CHK;
          end
        end
        S_COV_CHK: begin
          if (rd_off != next_q) begin
            state_q <= S_OUT;
          end else begin
            next_q  <= rd_end;
            idx_q   <= idx_q + CW'(1);
            state_q <= S_COV_RD;
          end
        end
        S_TICK: begin
          if (scan_q < (SW+1)'(SLOTS)) begin
            if (valid_q[scan_s]) begin
              age_q[scan_s] <= age_inc;
              if (age_inc > cfg_i.timeout_ticks) begin
                valid_q[scan_s] <= 1'b0;
                held_q <= (recv_q[scan_s] <= held_q) ? held_q - recv_q[scan_s] : '0;
                if (open_q != '0) open_q <= open_q - OW'(1);
                exp_q <= exp_q + 4'd1;
              end
            end
            scan_q <= scan_q + (SW+1)'(1);
          end else begin
            rsp_q.expired_count <= exp_q;
            state_q             <= S_OUT;
          end
        end
        S_FREE: begin
          valid_q[slot_q] <= 1'b0;
          held_q  <= (recv_s <= held_q) ? held_q - recv_s : '0;
          if (open_q != '0) open_q <= open_q - OW'(1);
          state_q <= S_OUT;
        end
        S_OUT: if (out_ready_i) state_q <= S_IDLE;
        default: state_q <= S_IDLE;
      endcase
    end
  end
endmodule

// ===== rtl/frt_checker.sv =====
module frt_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [3:0]  rsp_status,
  input logic        rsp_done,
  input logic        rsp_dup,
  input logic [3:0]  rsp_exp
);
  import frt_pkg::*;

  a_no_accept_while_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> !req_ready) else $error("input taken while result pending");
  a_err_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && rsp_status != ST_OK) |-> (!rsp_done && !rsp_dup && rsp_exp == 4'd0))
    else $error("error result with flags");
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid |-> (rsp_status <= ST_INCOMPLETE)) else $error("bad status");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_status)))
    else $error("result dropped");
endmodule

bind fragment_reassembly_tracker frt_checker u_chk (
  .clk_i, .rst_ni, .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_status(rsp.data.status),
  .rsp_done(rsp.data.done_res), .rsp_dup(rsp.data.was_duplicate),
  .rsp_exp(rsp.data.expired_count)
);
